/* rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RCVS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RCVS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rcvs_pkg.sv */
// package: opcodes, register indexes, serial unit types and saturation helper
package rcvs_pkg;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_SOLVE = 2'd2;

  localparam logic [7:0] CFG_FIXED_POINT_A  = 8'd0;
  localparam logic [7:0] CFG_FIXED_POINT_B  = 8'd1;
  localparam logic [7:0] CFG_ANCHOR_LOCAL   = 8'd2;
  localparam logic [7:0] CFG_CENTRE_LOCAL   = 8'd3;
  localparam logic [7:0] CFG_ROPE_LENGTH    = 8'd4;
  localparam logic [7:0] CFG_SOFTNESS       = 8'd5;
  localparam logic [7:0] CFG_ERROR_GAIN     = 8'd6;
  localparam logic [7:0] CFG_INVERSE_MASSES = 8'd7;

  localparam logic [30:0] SOFTNESS_RESET = 31'd6553600;
  localparam logic [30:0] GAIN_RESET     = 31'd6553600;

  typedef enum logic [1:0] {
    SK_MUL,
    SK_DIV,
    SK_SQRT
  } ser_kind_t;

  typedef struct packed {
    logic      start;
    ser_kind_t kind;
  } ser_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/rcvs_if.sv */
// channel interfaces: body word in, velocity word out, register write
interface rcvs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] body_pos_x;
  logic signed [31:0] body_pos_y;
  logic signed [17:0] rot_cos;
  logic signed [17:0] rot_sin;
  logic signed [31:0] body_angle;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] ang_vel;

  modport source (output valid, opcode, body_pos_x, body_pos_y, rot_cos, rot_sin,
                  body_angle, vel_x, vel_y, ang_vel, input ready);
  modport sink (input valid, opcode, body_pos_x, body_pos_y, rot_cos, rot_sin,
                body_angle, vel_x, vel_y, ang_vel, output ready);
endinterface

interface rcvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_ang_vel;

  modport source (output valid, new_vel_x, new_vel_y, new_ang_vel, input ready);
  modport sink (input valid, new_vel_x, new_vel_y, new_ang_vel, output ready);
endinterface

interface rcvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/rcvs_serial.sv */
// bit-serial arithmetic unit: signed multiply, signed divide, integer square root
module rcvs_serial (
  input  logic                clk,
  input  logic                rst,
  input  rcvs_pkg::ser_ctl_t  ctl,
  input  logic signed [63:0]  opa,
  input  logic signed [63:0]  opb,
  output logic                done,
  output logic signed [63:0]  res
);

  rcvs_pkg::ser_kind_t kind;
  logic        busy;
  logic        neg;
  logic [5:0]  cnt;
  logic [63:0] acc;
  logic [63:0] sh;
  logic [63:0] opd;

  logic [63:0] abs_a;
  logic [63:0] abs_b;
  logic [32:0] mul_sum;
  logic [64:0] div_trial;
  logic [64:0] div_diff;
  logic [35:0] sq_rem;
  logic [35:0] sq_trial;
  logic [5:0]  last_cnt;
  logic [63:0] mag;

  assign abs_a = opa[63] ? 64'(-opa) : 64'(opa);
  assign abs_b = opb[63] ? 64'(-opb) : 64'(opb);

  assign mul_sum   = {1'b0, acc[63:32]} + (sh[0] ? {1'b0, opd[31:0]} : 33'd0);
  assign div_trial = {acc, sh[63]};
  assign div_diff  = div_trial - {1'b0, opd};
  assign sq_rem    = {acc[33:0], sh[63:62]};
  assign sq_trial  = {2'b00, opd[31:0], 2'b01};
  assign last_cnt  = (kind == rcvs_pkg::SK_DIV) ? 6'd63 : 6'd31;

  always_comb begin
    unique case (kind)
      rcvs_pkg::SK_MUL:  mag = acc;
      rcvs_pkg::SK_DIV:  mag = sh;
      rcvs_pkg::SK_SQRT: mag = {32'd0, opd[31:0]};
      default:           mag = acc;
    endcase
    res = neg ? $signed(-mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      kind <= rcvs_pkg::SK_MUL;
      neg  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        kind <= ctl.kind;
        acc  <= '0;
        unique case (ctl.kind)
          rcvs_pkg::SK_MUL: begin
            neg <= opa[63] ^ opb[63];
            opd <= {32'd0, abs_a[31:0]};
            sh  <= {32'd0, abs_b[31:0]};
          end
          rcvs_pkg::SK_DIV: begin
            neg <= opa[63] ^ opb[63];
            opd <= abs_b;
            sh  <= abs_a;
          end
          rcvs_pkg::SK_SQRT: begin
            neg <= 1'b0;
            opd <= '0;
            sh  <= opa;
          end
          default: begin
            neg <= 1'b0;
          end
        endcase
      end else if (busy) begin
        unique case (kind)
          rcvs_pkg::SK_MUL: begin
            acc <= {mul_sum, acc[31:1]};
            sh  <= {1'b0, sh[63:1]};
          end
          rcvs_pkg::SK_DIV: begin
            acc <= div_diff[64] ? div_trial[63:0] : div_diff[63:0];
            sh  <= {sh[62:0], ~div_diff[64]};
          end
          rcvs_pkg::SK_SQRT: begin
            if (sq_rem >= sq_trial) begin
              acc <= {28'd0, sq_rem - sq_trial};
              opd <= {32'd0, opd[30:0], 1'b1};
            end else begin
              acc <= {28'd0, sq_rem};
              opd <= {32'd0, opd[30:0], 1'b0};
            end
            sh <= {sh[61:0], 2'b00};
          end
          default: begin
            acc <= acc;
          end
        endcase
        cnt <= cnt + 6'd1;
        if (cnt == last_cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/rope_constraint_velocity_solver.sv */
// top level: rope joint build and velocity solve sequencer around a bit-serial unit
//
//   port  dir  role                         word
//   cfg   in   register write               index, 64-bit data
//   req   in   body transform and velocity  opcode, pose, angle, velocities
//   rsp   out  corrected velocities         new_vel_x, new_vel_y, new_ang_vel
//
// init and unused opcodes skip the program; build runs steps 0 to 58, solve 64 to 103.
// add/sub steps of the program finish without the serial unit; multiplies, roots
// and divides all run on the one shared bit-serial unit.
// req is taken only between items; a finished word waits in the rsp register while the
// next item is accepted. rst is synchronous; it resets control, config and build state only.
`include "assert_macros.svh"

module rope_constraint_velocity_solver (
  input logic         clk,
  input logic         rst,
  rcvs_cfg_if.sink    cfg,
  rcvs_in_if.sink     req,
  rcvs_out_if.source  rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT, ST_HOLD} state_t;

  typedef enum logic [3:0] {
    U_ADD, U_SUB, U_ADDNP, U_MULQ, U_MULW, U_ADDW, U_HSUB,
    U_DIVQ, U_INV, U_INVN, U_SQRT, U_CLR
  } uop_t;

  typedef enum logic [4:0] {
    D_NONE, D_T0, D_T1, D_T2, D_T3, D_T4, D_T5, D_T6, D_T7, D_W0, D_W1,
    D_RX, D_RY, D_NX, D_NY, D_M0, D_M1, D_M2, D_M3, D_PB, D_AB,
    D_IMP0, D_IMP1, D_VX, D_VY, D_W
  } dst_t;

  localparam logic [6:0] SOLVE_START = 7'd64;

  state_t state;
  logic [6:0] step;

  logic [63:0] fpa, fpb, anc, cen, invm;
  logic [30:0] rlen, soft_mix, gain;

  logic signed [31:0] pos_x, pos_y, rc, rs, ang, vx, vy, wv;
  logic signed [31:0] ref_ang, rx, ry, nx, ny, m0, m1, m2, m3, pb, ab, imp0, imp1;
  logic signed [31:0] t0, t1, t2, t3, t4, t5, t6, t7;
  logic [63:0] w0, w1;
  logic signed [31:0] ovx, ovy, ow;

  uop_t mop;
  dst_t dst;
  logic last;
  logic signed [31:0] ua, ub;
  logic signed [31:0] softs, gains, rlens, im, ii, ax, ay, bx, by, alx, aly, clx, cly;

  rcvs_pkg::ser_ctl_t ser_ctl;
  logic signed [63:0] sa, sb, ser_res;
  logic ser_done;
  logic serial, skip, commit;
  logic signed [31:0] r32, sum32;
  logic [63:0] r64;

  assign softs = {1'b0, soft_mix};
  assign gains = {1'b0, gain};
  assign rlens = {1'b0, rlen};
  assign im  = invm[63:32];
  assign ii  = invm[31:0];
  assign ax  = fpa[63:32];
  assign ay  = fpa[31:0];
  assign bx  = fpb[63:32];
  assign by  = fpb[31:0];
  assign alx = anc[63:32];
  assign aly = anc[31:0];
  assign clx = cen[63:32];
  assign cly = cen[31:0];

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);

  // micro program
  always_comb begin
    mop  = U_ADD;
    ua   = 32'sd0;
    ub   = 32'sd0;
    dst  = D_NONE;
    last = 1'b0;
    unique case (step)
      7'd0:   begin mop = U_MULQ; ua = rc;   ub = clx;  dst = D_T0; end
      7'd1:   begin mop = U_MULQ; ua = rs;   ub = cly;  dst = D_T1; end
      7'd2:   begin mop = U_SUB;  ua = t0;   ub = t1;   dst = D_T2; end
      7'd3:   begin mop = U_MULQ; ua = rs;   ub = clx;  dst = D_T0; end
      7'd4:   begin mop = U_MULQ; ua = rc;   ub = cly;  dst = D_T1; end
      7'd5:   begin mop = U_ADD;  ua = t0;   ub = t1;   dst = D_T3; end
      7'd6:   begin mop = U_MULQ; ua = rc;   ub = alx;  dst = D_T0; end
      7'd7:   begin mop = U_MULQ; ua = rs;   ub = aly;  dst = D_T1; end
      7'd8:   begin mop = U_SUB;  ua = t0;   ub = t1;   dst = D_RX; end
      7'd9:   begin mop = U_MULQ; ua = rs;   ub = alx;  dst = D_T0; end
      7'd10:  begin mop = U_MULQ; ua = rc;   ub = aly;  dst = D_T1; end
      7'd11:  begin mop = U_ADD;  ua = t0;   ub = t1;   dst = D_RY; end
      7'd12:  begin mop = U_ADD;  ua = t2;   ub = pos_x; dst = D_T2; end
      7'd13:  begin mop = U_ADD;  ua = t2;   ub = rx;   dst = D_T2; end
      7'd14:  begin mop = U_ADD;  ua = t3;   ub = pos_y; dst = D_T3; end
      7'd15:  begin mop = U_ADD;  ua = t3;   ub = ry;   dst = D_T3; end
      7'd16:  begin mop = U_SUB;  ua = t2;   ub = ax;   dst = D_T4; end
      7'd17:  begin mop = U_SUB;  ua = t3;   ub = ay;   dst = D_T5; end
      7'd18:  begin mop = U_SUB;  ua = t2;   ub = bx;   dst = D_T6; end
      7'd19:  begin mop = U_SUB;  ua = t3;   ub = by;   dst = D_T7; end
      7'd20:  begin mop = U_MULW; ua = t4;   ub = t4;   dst = D_W0; end
      7'd21:  begin mop = U_MULW; ua = t5;   ub = t5;   dst = D_W1; end
      7'd22:  begin mop = U_ADDW;                       dst = D_W0; end
      7'd23:  begin mop = U_SQRT;                       dst = D_T0; end
      7'd24:  begin mop = U_MULW; ua = t6;   ub = t6;   dst = D_W0; end
      7'd25:  begin mop = U_MULW; ua = t7;   ub = t7;   dst = D_W1; end
      7'd26:  begin mop = U_ADDW;                       dst = D_W0; end
      7'd27:  begin mop = U_SQRT;                       dst = D_T1; end
      7'd28:  begin mop = U_DIVQ; ua = t4;   ub = t0;   dst = D_T4; end
      7'd29:  begin mop = U_DIVQ; ua = t5;   ub = t0;   dst = D_T5; end
      7'd30:  begin mop = U_DIVQ; ua = t6;   ub = t1;   dst = D_T6; end
      7'd31:  begin mop = U_DIVQ; ua = t7;   ub = t1;   dst = D_T7; end
      7'd32:  begin mop = U_ADD;  ua = t4;   ub = t6;   dst = D_NX; end
      7'd33:  begin mop = U_ADD;  ua = t5;   ub = t7;   dst = D_NY; end
      7'd34:  begin mop = U_ADD;  ua = t0;   ub = t1;   dst = D_T2; end
      7'd35:  begin mop = U_SUB;  ua = t2;   ub = rlens; dst = D_T2; end
      7'd36:  begin mop = U_MULQ; ua = gains; ub = t2;  dst = D_PB; end
      7'd37:  begin mop = U_SUB;  ua = ang;  ub = ref_ang; dst = D_T2; end
      7'd38:  begin mop = U_MULQ; ua = gains; ub = t2;  dst = D_AB; end
      7'd39:  begin mop = U_MULQ; ua = rx;   ub = ny;   dst = D_T2; end
      7'd40:  begin mop = U_MULQ; ua = ry;   ub = nx;   dst = D_T3; end
      7'd41:  begin mop = U_SUB;  ua = t2;   ub = t3;   dst = D_T2; end
      7'd42:  begin mop = U_MULQ; ua = ii;   ub = t2;   dst = D_T3; end
      7'd43:  begin mop = U_MULQ; ua = nx;   ub = nx;   dst = D_T4; end
      7'd44:  begin mop = U_MULQ; ua = ny;   ub = ny;   dst = D_T5; end
      7'd45:  begin mop = U_ADD;  ua = t4;   ub = t5;   dst = D_T4; end
      7'd46:  begin mop = U_MULQ; ua = im;   ub = t4;   dst = D_T4; end
      7'd47:  begin mop = U_MULQ; ua = t3;   ub = t2;   dst = D_T5; end
      7'd48:  begin mop = U_ADD;  ua = t4;   ub = t5;   dst = D_T4; end
      7'd49:  begin mop = U_ADD;  ua = t4;   ub = softs; dst = D_T4; end
      7'd50:  begin mop = U_ADD;  ua = ii;   ub = softs; dst = D_T5; end
      7'd51:  begin mop = U_MULW; ua = t4;   ub = t5;   dst = D_W0; end
      7'd52:  begin mop = U_MULW; ua = t3;   ub = t3;   dst = D_W1; end
      7'd53:  begin mop = U_HSUB;                       dst = D_W0; end
      7'd54:  begin mop = U_INV;  ua = t5;              dst = D_M0; end
      7'd55:  begin mop = U_INVN; ua = t3;              dst = D_M1; end
      7'd56:  begin mop = U_INVN; ua = t3;              dst = D_M2; end
      7'd57:  begin mop = U_INV;  ua = t4;              dst = D_M3; end
      7'd58:  begin mop = U_CLR;  last = 1'b1; end
      7'd64:  begin mop = U_SUB;  ua = 32'sd0; ub = wv; dst = D_T0; end
      7'd65:  begin mop = U_MULQ; ua = t0;   ub = ry;   dst = D_T0; end
      7'd66:  begin mop = U_ADD;  ua = vx;   ub = t0;   dst = D_T0; end
      7'd67:  begin mop = U_MULQ; ua = wv;   ub = rx;   dst = D_T1; end
      7'd68:  begin mop = U_ADD;  ua = vy;   ub = t1;   dst = D_T1; end
      7'd69:  begin mop = U_MULQ; ua = t0;   ub = nx;   dst = D_T0; end
      7'd70:  begin mop = U_MULQ; ua = t1;   ub = ny;   dst = D_T1; end
      7'd71:  begin mop = U_ADD;  ua = t0;   ub = t1;   dst = D_T0; end
      7'd72:  begin mop = U_ADD;  ua = t0;   ub = pb;   dst = D_T0; end
      7'd73:  begin mop = U_MULQ; ua = imp0; ub = softs; dst = D_T1; end
      7'd74:  begin mop = U_ADD;  ua = t0;   ub = t1;   dst = D_T0; end
      7'd75:  begin mop = U_ADD;  ua = wv;   ub = ab;   dst = D_T1; end
      7'd76:  begin mop = U_MULQ; ua = imp1; ub = softs; dst = D_T2; end
      7'd77:  begin mop = U_ADD;  ua = t1;   ub = t2;   dst = D_T1; end
      7'd78:  begin mop = U_MULQ; ua = m0;   ub = t0;   dst = D_T2; end
      7'd79:  begin mop = U_MULQ; ua = m1;   ub = t1;   dst = D_T3; end
      7'd80:  begin mop = U_ADD;  ua = t2;   ub = t3;   dst = D_T2; end
      7'd81:  begin mop = U_SUB;  ua = 32'sd0; ub = t2; dst = D_T2; end
      7'd82:  begin mop = U_MULQ; ua = m2;   ub = t0;   dst = D_T3; end
      7'd83:  begin mop = U_MULQ; ua = m3;   ub = t1;   dst = D_T4; end
      7'd84:  begin mop = U_ADD;  ua = t3;   ub = t4;   dst = D_T3; end
      7'd85:  begin mop = U_SUB;  ua = 32'sd0; ub = t3; dst = D_T3; end
      7'd86:  begin mop = U_ADDNP; ua = t2;  ub = imp0; dst = D_T2; end
      7'd87:  begin mop = U_SUB;  ua = t2;   ub = imp0; dst = D_T4; end
      7'd88:  begin mop = U_ADD;  ua = t2;              dst = D_IMP0; end
      7'd89:  begin mop = U_ADD;  ua = t3;   ub = imp1; dst = D_T3; end
      7'd90:  begin mop = U_SUB;  ua = t3;   ub = imp1; dst = D_T5; end
      7'd91:  begin mop = U_ADD;  ua = t3;              dst = D_IMP1; end
      7'd92:  begin mop = U_MULQ; ua = nx;   ub = t4;   dst = D_T0; end
      7'd93:  begin mop = U_MULQ; ua = ny;   ub = t4;   dst = D_T1; end
      7'd94:  begin mop = U_MULQ; ua = t0;   ub = im;   dst = D_T2; end
      7'd95:  begin mop = U_ADD;  ua = vx;   ub = t2;   dst = D_VX; end
      7'd96:  begin mop = U_MULQ; ua = t1;   ub = im;   dst = D_T2; end
      7'd97:  begin mop = U_ADD;  ua = vy;   ub = t2;   dst = D_VY; end
      7'd98:  begin mop = U_MULQ; ua = rx;   ub = t1;   dst = D_T2; end
      7'd99:  begin mop = U_MULQ; ua = ry;   ub = t0;   dst = D_T3; end
      7'd100: begin mop = U_SUB;  ua = t2;   ub = t3;   dst = D_T2; end
      7'd101: begin mop = U_ADD;  ua = t2;   ub = t5;   dst = D_T2; end
      7'd102: begin mop = U_MULQ; ua = ii;   ub = t2;   dst = D_T2; end
      7'd103: begin mop = U_ADD;  ua = wv;   ub = t2;   dst = D_W; last = 1'b1; end
      default: begin last = 1'b1; end
    endcase
  end

  // serial unit operands
  always_comb begin
    sa = 64'(ua);
    sb = 64'(ub);
    ser_ctl.kind = rcvs_pkg::SK_MUL;
    serial = 1'b0;
    skip   = 1'b0;
    case (mop)
      U_MULQ, U_MULW: begin
        serial = 1'b1;
      end
      U_DIVQ: begin
        serial = 1'b1;
        skip   = (ub == 32'sd0);
        sa     = 64'(ua) <<< 16;
        ser_ctl.kind = rcvs_pkg::SK_DIV;
      end
      U_INV, U_INVN: begin
        serial = 1'b1;
        skip   = (w0 == 64'd0);
        sa     = (mop == U_INVN) ? ((-64'(ua)) <<< 31) : (64'(ua) <<< 31);
        sb     = $signed(w0);
        ser_ctl.kind = rcvs_pkg::SK_DIV;
      end
      U_SQRT: begin
        serial = 1'b1;
        sa     = $signed(w0);
        ser_ctl.kind = rcvs_pkg::SK_SQRT;
      end
      default: begin
        serial = 1'b0;
      end
    endcase
    ser_ctl.start = (state == ST_EXEC) && serial && !skip;
  end

  rcvs_serial u_serial (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ser_ctl),
    .opa  (sa),
    .opb  (sb),
    .done (ser_done),
    .res  (ser_res)
  );

  // result of the current step
  always_comb begin
    r64 = ser_res;
    r32 = 32'sd0;
    sum32 = rcvs_pkg::sat32(64'(ua) + 64'(ub));
    case (mop)
      U_ADD:   r32 = sum32;
      U_SUB:   r32 = rcvs_pkg::sat32(64'(ua) - 64'(ub));
      U_ADDNP: r32 = (sum32 > 32'sd0) ? 32'sd0 : sum32;
      U_MULQ:  r32 = rcvs_pkg::sat32(ser_res >>> 16);
      U_DIVQ:  r32 = skip ? ua : rcvs_pkg::sat32(ser_res);
      U_INV, U_INVN: r32 = skip ? 32'sd0 : rcvs_pkg::sat32(ser_res);
      U_SQRT:  r32 = (ser_res[63:31] != 33'd0) ? 32'sh7fffffff : $signed(ser_res[31:0]);
      U_ADDW:  r64 = w0 + w1;
      U_HSUB:  r64 = 64'(($signed(w0) >>> 1) - ($signed(w1) >>> 1));
      default: r32 = 32'sd0;
    endcase
  end

  assign commit = ((state == ST_EXEC) && (!serial || skip)) ||
                  ((state == ST_WAIT) && ser_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      rsp.valid <= 1'b0;
      fpa <= '0; fpb <= '0; anc <= '0; cen <= '0; invm <= '0;
      rlen <= '0;
      soft_mix <= rcvs_pkg::SOFTNESS_RESET;
      gain <= rcvs_pkg::GAIN_RESET;
      ref_ang <= '0; rx <= '0; ry <= '0; nx <= '0; ny <= '0;
      m0 <= '0; m1 <= '0; m2 <= '0; m3 <= '0;
      pb <= '0; ab <= '0; imp0 <= '0; imp1 <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          rcvs_pkg::CFG_FIXED_POINT_A:  fpa  <= cfg.data;
          rcvs_pkg::CFG_FIXED_POINT_B:  fpb  <= cfg.data;
          rcvs_pkg::CFG_ANCHOR_LOCAL:   anc  <= cfg.data;
          rcvs_pkg::CFG_CENTRE_LOCAL:   cen  <= cfg.data;
          rcvs_pkg::CFG_ROPE_LENGTH:    rlen <= cfg.data[30:0];
          rcvs_pkg::CFG_SOFTNESS:       soft_mix <= cfg.data[30:0];
          rcvs_pkg::CFG_ERROR_GAIN:     gain <= cfg.data[30:0];
          rcvs_pkg::CFG_INVERSE_MASSES: invm <= cfg.data;
          default: ;
        endcase
      end

      if (rsp.valid && rsp.ready && (state != ST_HOLD)) begin
        rsp.valid <= 1'b0;
      end

      if (commit) begin
        if (mop == U_CLR) begin
          imp0 <= '0;
          imp1 <= '0;
        end
        unique case (dst)
          D_T0:   t0 <= r32;
          D_T1:   t1 <= r32;
          D_T2:   t2 <= r32;
          D_T3:   t3 <= r32;
          D_T4:   t4 <= r32;
          D_T5:   t5 <= r32;
          D_T6:   t6 <= r32;
          D_T7:   t7 <= r32;
          D_W0:   w0 <= r64;
          D_W1:   w1 <= r64;
          D_RX:   rx <= r32;
          D_RY:   ry <= r32;
          D_NX:   nx <= r32;
          D_NY:   ny <= r32;
          D_M0:   m0 <= r32;
          D_M1:   m1 <= r32;
          D_M2:   m2 <= r32;
          D_M3:   m3 <= r32;
          D_PB:   pb <= r32;
          D_AB:   ab <= r32;
          D_IMP0: imp0 <= r32;
          D_IMP1: imp1 <= r32;
          D_VX:   ovx <= r32;
          D_VY:   ovy <= r32;
          D_W:    ow <= r32;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            pos_x <= req.body_pos_x;
            pos_y <= req.body_pos_y;
            rc    <= 32'(req.rot_cos);
            rs    <= 32'(req.rot_sin);
            ang   <= req.body_angle;
            vx    <= req.vel_x;
            vy    <= req.vel_y;
            wv    <= req.ang_vel;
            ovx   <= req.vel_x;
            ovy   <= req.vel_y;
            ow    <= req.ang_vel;
            if (req.opcode == rcvs_pkg::OP_INIT) begin
              ref_ang <= req.body_angle;
              state   <= ST_HOLD;
            end else if (req.opcode == rcvs_pkg::OP_BUILD) begin
              step  <= '0;
              state <= ST_EXEC;
            end else if (req.opcode == rcvs_pkg::OP_SOLVE) begin
              step  <= SOLVE_START;
              state <= ST_EXEC;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        ST_EXEC, ST_WAIT: begin
          if (commit) begin
            if (last) begin
              state <= ST_HOLD;
            end else begin
              step  <= step + 7'd1;
              state <= ST_EXEC;
            end
          end else if (state == ST_EXEC) begin
            state <= ST_WAIT;
          end
        end
        ST_HOLD: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.new_vel_x   <= ovx;
            rsp.new_vel_y   <= ovy;
            rsp.new_ang_vel <= ow;
            rsp.valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `RCVS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, req.valid && req.ready, state != ST_IDLE)
  `RCVS_ASSERT_IMPL(a_done_only_waiting, clk, rst, ser_done, state == ST_WAIT)
  `RCVS_ASSERT_IMPL(a_rope_impulse_slack, clk, rst, 1'b1, imp0 <= 32'sd0)

endmodule

/* bench/rcvs_tb_if.sv */
`timescale 1ns / 100ps
// testbench package: body and velocity word types
package rcvs_tb_pkg;
  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] body_pos_x;
    logic signed [31:0] body_pos_y;
    logic signed [17:0] rot_cos;
    logic signed [17:0] rot_sin;
    logic signed [31:0] body_angle;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] ang_vel;
  } body_word_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_ang_vel;
  } vel_word_t;
endpackage

/* bench/rope_constraint_velocity_solver_test.sv */
`timescale 1ns / 100ps
// testbench for the rope constraint velocity solver: fixed-point predictor and checker
module rope_constraint_velocity_solver_test;
  import rcvs_pkg::*;
  import rcvs_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  always #5 clk = ~clk;

  rcvs_cfg_if cfg ();
  rcvs_in_if  req ();
  rcvs_out_if rsp ();

  rope_constraint_velocity_solver dut (.clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp));

  // predictor state
  logic [63:0] pt_a, pt_b, anc_l, cen_l, inv_m;
  logic [30:0] rope_len, soft_r, gain_r;
  int ref_ang, pbias, abias;
  int lever[2], ndir[2], minv[4], imp[2];

  vel_word_t expected_vel[$];
  int errors = 0;
  bit idle_on = 1;
  bit hold_rsp = 0;

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int qadd(int a, int b); return sat(longint'(a) + b); endfunction
  function automatic int qsub(int a, int b); return sat(longint'(a) - b); endfunction
  function automatic int qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat(p >>> 16);
  endfunction
  function automatic int qcross(int ax, int ay, int bx, int by);
    return qsub(qmul(ax, by), qmul(ay, bx));
  endfunction

  function automatic int vec_len(int x, int y);
    logic [63:0] ax, ay, v, r, b;
    ax = x < 0 ? -longint'(x) : longint'(x);
    ay = y < 0 ? -longint'(y) : longint'(y);
    v = ax * ax + ay * ay;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (r > 64'h7fffffff) return 32'h7fffffff;
    return int'(r);
  endfunction

  function automatic int qdiv(int num, int den);
    return sat((longint'(num) * 65536) / den);
  endfunction

  function automatic int inv_entry(longint num, longint h);
    return sat((num * 64'sd2147483648) / h);
  endfunction

  function automatic void write_register(logic [7:0] idx, logic [63:0] d);
    case (idx)
      CFG_FIXED_POINT_A:  pt_a = d;
      CFG_FIXED_POINT_B:  pt_b = d;
      CFG_ANCHOR_LOCAL:   anc_l = d;
      CFG_CENTRE_LOCAL:   cen_l = d;
      CFG_ROPE_LENGTH:    rope_len = d[30:0];
      CFG_SOFTNESS:       soft_r = d[30:0];
      CFG_ERROR_GAIN:     gain_r = d[30:0];
      CFG_INVERSE_MASSES: inv_m = d;
      default: ;
    endcase
  endfunction

  function automatic void build_rope(body_word_t w);
    int c, s, cx, cy, rx, ry, px, py, l1x, l1y, l2x, l2y, len1, len2;
    int nx, ny, rc, im, ii, sf, k11, k12, k22;
    longint h;
    c = w.rot_cos;
    s = w.rot_sin;
    cx = qsub(qmul(c, cen_l[63:32]), qmul(s, cen_l[31:0]));
    cy = qadd(qmul(s, cen_l[63:32]), qmul(c, cen_l[31:0]));
    rx = qsub(qmul(c, anc_l[63:32]), qmul(s, anc_l[31:0]));
    ry = qadd(qmul(s, anc_l[63:32]), qmul(c, anc_l[31:0]));
    px = qadd(qadd(cx, w.body_pos_x), rx);
    py = qadd(qadd(cy, w.body_pos_y), ry);
    lever[0] = rx;
    lever[1] = ry;
    l1x = qsub(px, pt_a[63:32]);
    l1y = qsub(py, pt_a[31:0]);
    l2x = qsub(px, pt_b[63:32]);
    l2y = qsub(py, pt_b[31:0]);
    len1 = vec_len(l1x, l1y);
    len2 = vec_len(l2x, l2y);
    if (len1 > 0) begin
      l1x = qdiv(l1x, len1);
      l1y = qdiv(l1y, len1);
    end
    if (len2 > 0) begin
      l2x = qdiv(l2x, len2);
      l2y = qdiv(l2y, len2);
    end
    nx = qadd(l1x, l2x);
    ny = qadd(l1y, l2y);
    ndir[0] = nx;
    ndir[1] = ny;
    rc = qcross(rx, ry, nx, ny);
    im = inv_m[63:32];
    ii = inv_m[31:0];
    sf = int'({1'b0, soft_r});
    k11 = qadd(qadd(qmul(im, qadd(qmul(nx, nx), qmul(ny, ny))), qmul(qmul(ii, rc), rc)), sf);
    k12 = qmul(ii, rc);
    k22 = qadd(ii, sf);
    h = ((longint'(k11) * k22) >>> 1) - ((longint'(k12) * k12) >>> 1);
    if (h == 0) begin
      minv = '{0, 0, 0, 0};
    end else begin
      minv[0] = inv_entry(k22, h);
      minv[1] = inv_entry(-longint'(k12), h);
      minv[2] = minv[1];
      minv[3] = inv_entry(k11, h);
    end
    pbias = qmul(int'({1'b0, gain_r}), qsub(qadd(len1, len2), int'({1'b0, rope_len})));
    abias = qmul(int'({1'b0, gain_r}), qsub(w.body_angle, ref_ang));
    imp = '{0, 0};
  endfunction

  function automatic vel_word_t solve_rope(body_word_t w);
    int rx, ry, nx, ny, sf, im, ii, wx, wy, cd, c0, c1, d0, d1, o0, o1, n0, n1, jx, jy;
    vel_word_t r;
    rx = lever[0];
    ry = lever[1];
    nx = ndir[0];
    ny = ndir[1];
    sf = int'({1'b0, soft_r});
    im = inv_m[63:32];
    ii = inv_m[31:0];
    wx = qadd(w.vel_x, qmul(qsub(0, w.ang_vel), ry));
    wy = qadd(w.vel_y, qmul(w.ang_vel, rx));
    cd = qadd(qmul(wx, nx), qmul(wy, ny));
    c0 = qadd(qadd(cd, pbias), qmul(imp[0], sf));
    c1 = qadd(qadd(w.ang_vel, abias), qmul(imp[1], sf));
    d0 = qsub(0, qadd(qmul(minv[0], c0), qmul(minv[1], c1)));
    d1 = qsub(0, qadd(qmul(minv[2], c0), qmul(minv[3], c1)));
    o0 = imp[0];
    o1 = imp[1];
    n0 = qadd(d0, o0);
    if (n0 > 0) n0 = 0;
    n1 = qadd(d1, o1);
    imp[0] = n0;
    imp[1] = n1;
    d0 = qsub(n0, o0);
    d1 = qsub(n1, o1);
    jx = qmul(nx, d0);
    jy = qmul(ny, d0);
    r.new_vel_x = qadd(w.vel_x, qmul(jx, im));
    r.new_vel_y = qadd(w.vel_y, qmul(jy, im));
    r.new_ang_vel = qadd(w.ang_vel, qmul(ii, qadd(qcross(rx, ry, jx, jy), d1)));
    return r;
  endfunction

  function automatic vel_word_t predict_velocity(body_word_t w);
    vel_word_t r;
    r.new_vel_x = w.vel_x;
    r.new_vel_y = w.vel_y;
    r.new_ang_vel = w.ang_vel;
    case (w.opcode)
      OP_INIT:  ref_ang = w.body_angle;
      OP_BUILD: build_rope(w);
      OP_SOLVE: r = solve_rope(w);
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit idle_now();
    return idle_on && ($urandom_range(99) < 27);
  endfunction

  // drive defaults
  initial begin
    cfg.valid = 0;
    cfg.index = 0;
    cfg.data = 0;
    req.valid = 0;
    {req.opcode, req.body_pos_x, req.body_pos_y, req.rot_cos, req.rot_sin,
     req.body_angle, req.vel_x, req.vel_y, req.ang_vel} = '0;
    rsp.ready = 0;
  end

  // receiver side
  always @(negedge clk) begin
    if (rst) rsp.ready <= 0;
    else rsp.ready <= !hold_rsp && !idle_now();
  end

  // result checker
  always @(posedge clk) begin
    vel_word_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_vel.size() == 0) begin
        $error("unexpected word");
        errors++;
      end else begin
        e = expected_vel.pop_front();
        if (rsp.new_vel_x !== e.new_vel_x) begin
          $error("new_vel_x expected %h actual %h", e.new_vel_x, rsp.new_vel_x);
          errors++;
        end
        if (rsp.new_vel_y !== e.new_vel_y) begin
          $error("new_vel_y expected %h actual %h", e.new_vel_y, rsp.new_vel_y);
          errors++;
        end
        if (rsp.new_ang_vel !== e.new_ang_vel) begin
          $error("new_ang_vel expected %h actual %h", e.new_ang_vel, rsp.new_ang_vel);
          errors++;
        end
      end
    end
  end

  task automatic send_word(body_word_t w);
    while (idle_now()) @(negedge clk);
    req.valid <= 1;
    {req.opcode, req.body_pos_x, req.body_pos_y, req.rot_cos, req.rot_sin,
     req.body_angle, req.vel_x, req.vel_y, req.ang_vel} <= w;
    do @(posedge clk); while (!req.ready);
    expected_vel.push_back(predict_velocity(w));
    @(negedge clk);
    req.valid <= 0;
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [63:0] d);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    write_register(idx, d);
    @(negedge clk);
    cfg.valid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_vel.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic int rand_q(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic body_word_t random_body(logic [1:0] op);
    body_word_t w;
    int a;
    w.opcode = op;
    w.body_pos_x = rand_q(20 << 16);
    w.body_pos_y = rand_q(20 << 16);
    a = $urandom_range(3);
    w.rot_cos = (a == 0) ? 18'sd65536 : 18'(rand_q(65536));
    w.rot_sin = (a == 0) ? 18'sd0 : 18'(rand_q(65536));
    w.body_angle = rand_q(4 << 16);
    w.vel_x = rand_q(50 << 16);
    w.vel_y = rand_q(50 << 16);
    w.ang_vel = rand_q(10 << 16);
    if ($urandom_range(9) == 0) begin
      w.body_pos_x = $urandom();
      w.body_pos_y = $urandom();
      w.rot_cos = 18'($urandom());
      w.rot_sin = 18'($urandom());
      w.body_angle = $urandom();
      w.vel_x = $urandom();
      w.vel_y = $urandom();
      w.ang_vel = $urandom();
    end
    return w;
  endfunction

  function automatic logic [63:0] rand_pair(int span);
    return {32'(rand_q(span)), 32'(rand_q(span))};
  endfunction

  task automatic random_config();
    write_cfg(CFG_FIXED_POINT_A, rand_pair(20 << 16));
    write_cfg(CFG_FIXED_POINT_B, rand_pair(20 << 16));
    write_cfg(CFG_ANCHOR_LOCAL, rand_pair(2 << 16));
    write_cfg(CFG_CENTRE_LOCAL, rand_pair(2 << 16));
    write_cfg(CFG_ROPE_LENGTH, 64'($urandom_range(60 << 16)));
    write_cfg(CFG_SOFTNESS, 64'($urandom_range(1 << 16)));
    write_cfg(CFG_ERROR_GAIN, 64'($urandom_range(10 << 16)));
    write_cfg(CFG_INVERSE_MASSES, {32'($urandom_range(2 << 16)), 32'($urandom_range(2 << 16))});
  endtask

  task automatic test_defaults();
    body_word_t w;
    w = random_body(OP_SOLVE);
    send_word(w);
    w = random_body(OP_BUILD);
    send_word(w);
    w = random_body(OP_SOLVE);
    send_word(w);
    drain();
  endtask

  task automatic test_directed();
    body_word_t w;
    random_config();
    w = random_body(OP_INIT);
    send_word(w);
    w = random_body(OP_BUILD);
    send_word(w);
    repeat (3) begin
      w = random_body(OP_SOLVE);
      send_word(w);
    end
    w = random_body(2'd3);
    send_word(w);
    // field extremes
    w = '{OP_BUILD, 32'h7fffffff, 32'h80000000, 18'sd65536, -18'sd65536,
          32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
    send_word(w);
    w.opcode = OP_SOLVE;
    send_word(w);
    w = '{OP_BUILD, 0, 0, 18'h1ffff, 18'h20000, 32'h80000000, 0, 0, 32'h80000000};
    send_word(w);
    w.opcode = OP_SOLVE;
    send_word(w);
    drain();
    // body anchor exactly on both fixed points: zero length
    write_cfg(CFG_FIXED_POINT_A, 64'd0);
    write_cfg(CFG_FIXED_POINT_B, 64'd0);
    write_cfg(CFG_ANCHOR_LOCAL, 64'd0);
    write_cfg(CFG_CENTRE_LOCAL, 64'd0);
    write_cfg(CFG_INVERSE_MASSES, 64'd0);
    write_cfg(CFG_SOFTNESS, 64'd0);
    w = '{OP_BUILD, 0, 0, 18'sd65536, 0, 0, 32'h10000, 32'h20000, 32'h30000};
    send_word(w);
    w.opcode = OP_SOLVE;
    send_word(w);
    drain();
    // extreme register values
    write_cfg(CFG_FIXED_POINT_A, 64'hffffffffffffffff);
    write_cfg(CFG_FIXED_POINT_B, 64'h7fffffff80000000);
    write_cfg(CFG_ANCHOR_LOCAL, 64'h800000007fffffff);
    write_cfg(CFG_CENTRE_LOCAL, 64'hffffffffffffffff);
    write_cfg(CFG_ROPE_LENGTH, 64'h7fffffff);
    write_cfg(CFG_SOFTNESS, 64'h7fffffff);
    write_cfg(CFG_ERROR_GAIN, 64'h7fffffff);
    write_cfg(CFG_INVERSE_MASSES, 64'hffffffffffffffff);
    write_cfg(8'd200, 64'h1234);
    w = random_body(OP_BUILD);
    send_word(w);
    w = random_body(OP_SOLVE);
    send_word(w);
    drain();
  endtask

  task automatic test_random(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if (sent % 300 == 0) begin
        drain();
        random_config();
      end
      if ($urandom_range(9) == 0) begin
        send_word(random_body(2'($urandom_range(3))));
        sent++;
      end else begin
        send_word(random_body(OP_INIT));
        send_word(random_body(OP_BUILD));
        sent += 2;
        repeat ($urandom_range(1, 4)) begin
          send_word(random_body(OP_SOLVE));
          sent++;
        end
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rsp = 1;
        repeat (4000) @(negedge clk);
        hold_rsp = 0;
      end
      repeat (6) send_word(random_body(2'($urandom_range(2))));
    join
    drain();
  endtask

  initial begin
    pt_a = 0; pt_b = 0; anc_l = 0; cen_l = 0; inv_m = 0;
    rope_len = 0; soft_r = SOFTNESS_RESET; gain_r = GAIN_RESET;
    ref_ang = 0; pbias = 0; abias = 0;
    lever = '{0, 0}; ndir = '{0, 0}; minv = '{0, 0, 0, 0}; imp = '{0, 0};
    repeat (3) @(negedge clk);
    rst = 0;
    test_defaults();
    test_directed();
    test_backpressure();
    idle_on = 0;
    test_random(200);
    idle_on = 1;
    test_random(1200);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end
endmodule
